/* hw/rtl/svpg_pkg.sv */
// shared types, constants and widths for the servo pulse generator
`default_nettype none
package svpg_pkg;

  // block configuration
  localparam int NUM_CHANNELS  = 6;
  localparam int ACCEL_ENABLE  = 1;
  localparam int MID_ANGLE_DEG = 90;
  localparam int FRAC_BITS     = 8;

  // fixed field widths
  localparam int CH_W          = 3;
  localparam int ANG_W         = 17;
  localparam int DEG_CFG_W     = 9;
  localparam int PULSE_W       = 12;
  localparam int SPEED_W       = 16;
  localparam int MASK_W        = 6;
  localparam int TRIM_W        = 10;
  localparam int TRIM_CHANNELS = 6;
  localparam int TRIM_WORDS_W  = 60;
  localparam int CFG_W         = 60;
  localparam int CFG_IDX_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_WORDS   = 3'd7;

  // fixed point derived values
  localparam int ONE_DEG      = 1 << FRAC_BITS;
  localparam int SETTLE_UNITS = (ONE_DEG + 50) / 100;
  localparam int POS_MAX_I    = (1 << (ANG_W - 1)) - 1;
  localparam int POS_MIN_I    = -(1 << (ANG_W - 1));
  localparam int MID_FIX_I    = MID_ANGLE_DEG * ONE_DEG;
  localparam int POS_RESET_I  = (MID_FIX_I > POS_MAX_I) ? POS_MAX_I :
                                ((MID_FIX_I < POS_MIN_I) ? POS_MIN_I : MID_FIX_I);
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // pulse mapping widths
  localparam int VAL_W     = ((DEG_CFG_W + FRAC_BITS > ANG_W) ?
                              (DEG_CFG_W + FRAC_BITS) : ANG_W) + 2;
  localparam int DEG_W     = VAL_W - FRAC_BITS;
  localparam int OFS_W     = DEG_W + 1;
  localparam int PDIFF_W   = PULSE_W + 1;
  localparam int SPAN_W    = DEG_CFG_W + 1;
  localparam int MAG_W     = OFS_W + PDIFF_W;
  localparam int US_W      = MAG_W + 2;
  localparam int DIV_STEPS = (MAG_W + 1) / 2;
  localparam int DIV_BITS  = 2 * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [ANG_W-1:0] target;
    logic                    in_range;
  } item_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_res_t;

endpackage
`default_nettype wire

/* hw/rtl/svpg_front.sv */
// front end: accepts input words, classifies the channel and feeds the queue
`default_nettype none
module svpg_front import svpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CH_W-1:0]         channel,
  input  logic signed [ANG_W-1:0] target_angle,
  input  q_stat_t                 q_stat,
  output logic                    push,
  output item_t                   push_item
);

  logic  hold_valid;
  item_t hold_item;
  logic  accept;

  assign in_stall  = hold_valid && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = hold_valid && !q_stat.full;
  assign push_item = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item.channel  <= channel;
      hold_item.target   <= target_angle;
      hold_item.in_range <= (32'(channel) < NUM_CHANNELS);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/svpg_queue.sv */
// short fifo between the front end and the motion back end
`default_nettype none
module svpg_queue import svpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t q_stat
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign pop_item     = entries[rd_ptr];
  assign q_stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_stat.avail = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/svpg_div.sv */
// unsigned restoring divider, two quotient bits per cycle
`default_nettype none
module svpg_div import svpg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  dividend,
  input  logic [SPAN_W-1:0] divisor,
  output div_res_t          res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SPAN_W:0]      rem;
  logic [DIV_BITS-1:0]  quo;
  logic [SPAN_W-1:0]    dvs;
  logic [SPAN_W:0]      rem_next;
  logic [DIV_BITS-1:0]  quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      rem_next = {rem_next[SPAN_W-1:0], quo_next[DIV_BITS-1]};
      quo_next = {quo_next[DIV_BITS-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  assign res.done     = done;
  assign res.quotient = quo[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= DIV_BITS'(dividend);
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/svpg_back.sv */
// back end: per-channel motion update, angle to pulse mapping, result register
`default_nettype none
module svpg_back import svpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  q_stat_t                 q_stat,
  input  item_t                   q_item,
  output logic                    pop,
  output logic                    div_start,
  output logic [MAG_W-1:0]        div_dividend,
  output logic [SPAN_W-1:0]       div_divisor,
  input  div_res_t                div_res,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [PULSE_W-1:0]      pulse_width,
  output logic signed [ANG_W-1:0] current_angle,
  output logic                    settled
);

  localparam int D_W   = ANG_W + 1;
  localparam int SUM_W = ANG_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(POS_MAX_I);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(POS_MIN_I);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_DIST  = 12'b000000000010,
    ST_DES   = 12'b000000000100,
    ST_VEL   = 12'b000000001000,
    ST_POS   = 12'b000000010000,
    ST_MAP   = 12'b000000100000,
    ST_DEG   = 12'b000001000000,
    ST_MUL   = 12'b000010000000,
    ST_START = 12'b000100000000,
    ST_DIV   = 12'b001000000000,
    ST_FIN   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [DEG_CFG_W-1:0] angle_min;
  logic signed [DEG_CFG_W-1:0] angle_max;
  logic [PULSE_W-1:0]          pulse_min;
  logic [PULSE_W-1:0]          pulse_max;
  logic [SPEED_W-1:0]          speed_limit;
  logic [SPEED_W-1:0]          accel_step;
  logic [MASK_W-1:0]           reverse_mask;
  logic [TRIM_WORDS_W-1:0]     trim_words;

  // per-channel state
  logic signed [ANG_W-1:0] pos_store [NUM_CHANNELS];
  logic signed [ANG_W-1:0] vel_store [NUM_CHANNELS];

  // working registers
  logic [CH_W-1:0]           item_ch;
  logic [CH_IDX_W-1:0]       item_idx;
  logic signed [ANG_W-1:0]   target;
  logic signed [ANG_W-1:0]   pos_r;
  logic signed [ANG_W-1:0]   vel_r;
  logic signed [D_W-1:0]     d_r;
  logic                      far_r;
  logic signed [D_W-1:0]     desired_r;
  logic signed [ANG_W-1:0]   vel_n;
  logic signed [ANG_W-1:0]   pos_f;
  logic                      settled_r;
  logic signed [VAL_W-1:0]   val_r;
  logic signed [OFS_W-1:0]   ofs_r;
  logic signed [MAG_W-1:0]   prod_r;
  logic signed [SPAN_W-1:0]  span_r;
  logic                      neg_r;
  logic signed [US_W-1:0]    us_r;
  logic [PULSE_W-1:0]        res_pulse;

  // combinational helpers
  logic                      in_trim;
  logic [MASK_W-1:0]         rev_bits;
  logic                      rev;
  logic [D_W-1:0]            mag;
  logic [D_W-1:0]            lim;
  logic signed [SUM_W-1:0]   v_ext;
  logic signed [SUM_W-1:0]   des_ext;
  logic signed [SUM_W-1:0]   v_try;
  logic signed [SUM_W-1:0]   v_new;
  logic signed [SUM_W-1:0]   p_sum;
  logic signed [ANG_W-1:0]   p_sat;
  logic signed [ANG_W-1:0]   pos_c;
  logic signed [ANG_W-1:0]   vel_c;
  logic signed [VAL_W-1:0]   val_c;
  logic signed [VAL_W-1:0]   val_adj;
  logic signed [DEG_W-1:0]   deg;
  logic signed [PDIFF_W-1:0] pdiff;
  logic [MAG_W-1:0]          prod_mag;
  logic [SPAN_W-1:0]         span_mag;
  logic signed [US_W-1:0]    q_ext;
  logic signed [US_W-1:0]    pmin_s;
  logic signed [US_W-1:0]    pmax_s;
  logic [TRIM_WORDS_W-1:0]   trim_shift;
  logic signed [US_W-1:0]    trim_s;
  logic signed [US_W-1:0]    us_t;
  logic [PULSE_W-1:0]        pulse_c;
  logic                      out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && q_stat.avail;

  assign in_trim  = (32'(item_ch) < TRIM_CHANNELS);
  assign rev_bits = reverse_mask >> item_ch;
  assign rev      = in_trim && rev_bits[0];
  assign pmin_s   = US_W'($signed({1'b0, pulse_min}));
  assign pmax_s   = US_W'($signed({1'b0, pulse_max}));

  // velocity target from the distance
  always_comb begin
    mag = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
    lim = (mag < D_W'(speed_limit)) ? mag : D_W'(speed_limit);
  end

  // velocity moves toward the target by at most one acceleration step
  always_comb begin
    v_ext   = SUM_W'(vel_r);
    des_ext = SUM_W'(desired_r);
    v_try   = v_ext;
    v_new   = v_ext;
    if (v_ext < des_ext) begin
      v_try = v_ext + SUM_W'($signed({1'b0, accel_step}));
      v_new = (v_try > des_ext) ? des_ext : v_try;
    end else if (v_ext > des_ext) begin
      v_try = v_ext - SUM_W'($signed({1'b0, accel_step}));
      v_new = (v_try < des_ext) ? des_ext : v_try;
    end
  end

  // position update with saturation and overshoot snap, or a direct jump to the target when acceleration is off
  always_comb begin
    p_sum = SUM_W'(pos_r) + SUM_W'(vel_n);
    if (p_sum > SUM_HI) begin
      p_sat = ANG_W'(SUM_HI);
    end else if (p_sum < SUM_LO) begin
      p_sat = ANG_W'(SUM_LO);
    end else begin
      p_sat = ANG_W'(p_sum);
    end
    if (ACCEL_ENABLE != 0) begin
      if (far_r) begin
        if ((!d_r[D_W-1] && p_sat >= target) || (d_r[D_W-1] && p_sat <= target)) begin
          pos_c = target;
          vel_c = '0;
        end else begin
          pos_c = p_sat;
          vel_c = vel_n;
        end
      end else begin
        pos_c = pos_r;
        vel_c = '0;
      end
    end else begin
      pos_c = target;
      vel_c = vel_r;
    end
  end

  // mirrored angle and whole degrees truncated toward zero
  always_comb begin
    if (rev) begin
      val_c = (VAL_W'(angle_min) <<< FRAC_BITS) + (VAL_W'(angle_max) <<< FRAC_BITS)
              - VAL_W'(pos_f);
    end else begin
      val_c = VAL_W'(pos_f);
    end
    val_adj = val_r + (val_r[VAL_W-1] ? VAL_W'(ONE_DEG - 1) : VAL_W'(0));
    deg     = DEG_W'(val_adj >>> FRAC_BITS);
    pdiff   = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
  end

  // divider operands and final trim and clamp
  always_comb begin
    prod_mag     = prod_r[MAG_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
    span_mag     = span_r[SPAN_W-1] ? SPAN_W'(-span_r) : SPAN_W'(span_r);
    div_dividend = prod_mag;
    div_divisor  = span_mag;
    div_start    = (state == ST_START) && (span_r != '0);
    q_ext        = US_W'(div_res.quotient);
    trim_shift   = trim_words >> (TRIM_W * item_ch);
    trim_s       = in_trim ? US_W'($signed(trim_shift[TRIM_W-1:0])) : US_W'(0);
    us_t         = us_r + trim_s;
    if (us_t < pmin_s) begin
      pulse_c = pulse_min;
    end else if (us_t > pmax_s) begin
      pulse_c = pulse_max;
    end else begin
      pulse_c = us_t[PULSE_W-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_min    <= DEG_CFG_W'(0);
      angle_max    <= DEG_CFG_W'(180);
      pulse_min    <= PULSE_W'(1000);
      pulse_max    <= PULSE_W'(2000);
      speed_limit  <= SPEED_W'(512);
      accel_step   <= SPEED_W'(26);
      reverse_mask <= '0;
      trim_words   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ANGLE_MIN:    angle_min    <= cfg_data[DEG_CFG_W-1:0];
        REG_ANGLE_MAX:    angle_max    <= cfg_data[DEG_CFG_W-1:0];
        REG_PULSE_MIN:    pulse_min    <= cfg_data[PULSE_W-1:0];
        REG_PULSE_MAX:    pulse_max    <= cfg_data[PULSE_W-1:0];
        REG_SPEED_LIMIT:  speed_limit  <= cfg_data[SPEED_W-1:0];
        REG_ACCEL_STEP:   accel_step   <= cfg_data[SPEED_W-1:0];
        REG_REVERSE_MASK: reverse_mask <= cfg_data[MASK_W-1:0];
        REG_TRIM_WORDS:   trim_words   <= cfg_data[TRIM_WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_store[i] <= ANG_W'(POS_RESET_I);
        vel_store[i] <= '0;
      end
    end else if (state == ST_POS) begin
      pos_store[item_idx] <= pos_c;
      vel_store[item_idx] <= vel_c;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_stat.avail) begin
            state <= q_item.in_range ? ST_DIST : ST_DONE;
          end
        end
        ST_DIST:  state <= ST_DES;
        ST_DES:   state <= ST_VEL;
        ST_VEL:   state <= ST_POS;
        ST_POS:   state <= ST_MAP;
        ST_MAP:   state <= ST_DEG;
        ST_DEG:   state <= ST_MUL;
        ST_MUL:   state <= ST_START;
        ST_START: state <= (span_r == '0) ? ST_FIN : ST_DIV;
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN:   state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item_ch   <= q_item.channel;
        item_idx  <= CH_IDX_W'(q_item.channel);
        target    <= q_item.target;
        res_pulse <= '0;
        pos_f     <= '0;
        settled_r <= 1'b0;
      end
      ST_DIST: begin
        pos_r <= pos_store[item_idx];
        vel_r <= vel_store[item_idx];
        d_r   <= D_W'(target) - D_W'(pos_store[item_idx]);
      end
      ST_DES: begin
        far_r     <= (mag > D_W'(SETTLE_UNITS));
        desired_r <= d_r[D_W-1] ? -$signed(lim) : $signed(lim);
      end
      ST_VEL: begin
        vel_n <= ANG_W'(v_new);
      end
      ST_POS: begin
        pos_f     <= pos_c;
        settled_r <= (pos_c == target) && (vel_c == '0);
      end
      ST_MAP: begin
        val_r <= val_c;
      end
      ST_DEG: begin
        ofs_r <= OFS_W'(deg) - OFS_W'(angle_min);
      end
      ST_MUL: begin
        prod_r <= MAG_W'(ofs_r) * MAG_W'(pdiff);
        span_r <= SPAN_W'(angle_max) - SPAN_W'(angle_min);
      end
      ST_START: begin
        neg_r <= prod_r[MAG_W-1] ^ span_r[SPAN_W-1];
        us_r  <= pmin_s;
      end
      ST_DIV: begin
        if (div_res.done) begin
          us_r <= (neg_r ? -q_ext : q_ext) + pmin_s;
        end
      end
      ST_FIN: begin
        res_pulse <= pulse_c;
      end
      ST_DONE: begin
        if (out_free) begin
          out_channel   <= item_ch;
          pulse_width   <= res_pulse;
          current_angle <= pos_f;
          settled       <= settled_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/servo_accel_limited_pulse_gen.sv */
// an accepted word for a valid channel passes the front-end holding register, the queue,
// the motion update and the pulse mapping; a channel beyond the last one skips to the result
// the back-end sequencer takes one word at a time and waits on its iterative divider for the
// angle-to-pulse mapping; the front end and a 2-entry queue take further words meanwhile;
// a stalled result holds the back end until it is taken
// reset: synchronous; configuration registers return to defaults, positions to mid angle, velocities to zero
`default_nettype none
module servo_accel_limited_pulse_gen import svpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CH_W-1:0]         channel,
  input  logic signed [ANG_W-1:0] target_angle,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [PULSE_W-1:0]      pulse_width,
  output logic signed [ANG_W-1:0] current_angle,
  output logic                    settled
);

  q_stat_t           q_stat;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             q_item;
  logic              div_start;
  logic [MAG_W-1:0]  div_dividend;
  logic [SPAN_W-1:0] div_divisor;
  div_res_t          div_res;

  svpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .channel      (channel),
    .target_angle (target_angle),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  svpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (q_item),
    .q_stat    (q_stat)
  );

  svpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  svpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_stat        (q_stat),
    .q_item        (q_item),
    .pop           (pop),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_res       (div_res),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_channel   (out_channel),
    .pulse_width   (pulse_width),
    .current_angle (current_angle),
    .settled       (settled)
  );

endmodule
`default_nettype wire

/* hw/rtl/svpg_checker.sv */
// port-level checks for the servo pulse generator, bound to the top level
`default_nettype none
module svpg_checker import svpg_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [CH_W-1:0]         channel,
  input logic signed [ANG_W-1:0] target_angle,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [CH_W-1:0]         out_channel,
  input logic [PULSE_W-1:0]      pulse_width,
  input logic signed [ANG_W-1:0] current_angle,
  input logic                    settled
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
    $stable(pulse_width) && $stable(current_angle) && $stable(settled))
    else $error("stalled result word changed");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(channel) && $stable(target_angle))
    else $error("stalled input word changed");

  // a channel beyond the last one reports zeros
  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(out_channel) >= NUM_CHANNELS) |->
    (pulse_width == '0) && (current_angle == '0) && !settled)
    else $error("out-of-range channel returned nonzero result");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the input holding stage
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind servo_accel_limited_pulse_gen svpg_checker u_svpg_checker (.*);
`default_nettype wire
